/* rtl/core/sus_pkg.sv */
// Shared types and codes for the sorted unique key set.
// Used by sus_cell and sorted_unique_key_set_top; depends on nothing.
`default_nettype none

package sus_pkg;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_SEARCH = 2'd2,
        OP_LIST   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        STAT_OK        = 3'd0,
        STAT_DUP       = 3'd1,
        STAT_NOT_FOUND = 3'd2,
        STAT_FULL      = 3'd3,
        STAT_EMPTY     = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_DELETE = 2'd2,
        CELL_ROTATE = 2'd3
    } cell_cmd_t;

    typedef enum logic {
        SEQ_IDLE = 1'b0,
        SEQ_LIST = 1'b1
    } seq_state_t;

    typedef struct packed {
        op_t                operation;
        logic signed [31:0] key;
    } request_t;

    typedef struct packed {
        status_t            status;
        logic signed [31:0] value;
        logic [4:0]         entry_count;
        logic               last;
    } result_t;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        cell_cmd_t          cmd;
        logic signed [31:0] key;
    } cell_ctl_t;

endpackage

`default_nettype wire

/* rtl/core/sus_cell.sv */
// One slot of the sorted key chain: holds a key, compares it with the
// broadcast key and shifts toward either neighbor. Depends on sus_pkg.
`default_nettype none

module sus_cell (
    input  wire logic               clk,
    input  wire logic               occupied,
    input  wire logic               tail,
    input  wire sus_pkg::cell_ctl_t ctl,
    input  wire logic               left_lt,
    input  wire logic signed [31:0] left_key,
    input  wire logic signed [31:0] right_key,
    input  wire logic signed [31:0] wrap_key,
    output logic signed [31:0]      key,
    output logic                    lt,
    output logic                    eq
);

    logic signed [31:0] key_reg;
    logic signed [31:0] key_next;

    assign key = key_reg;
    assign lt  = occupied && (key_reg < ctl.key);
    assign eq  = occupied && (key_reg == ctl.key);

    always_comb
    begin
        key_next = key_reg;
        unique case (ctl.cmd)
            sus_pkg::CELL_HOLD:
            begin
                key_next = key_reg;
            end
            sus_pkg::CELL_INSERT:
            begin
                // first cell not below the key takes it, later cells move up
                if (lt)
                begin
                    key_next = key_reg;
                end
                else if (left_lt)
                begin
                    key_next = ctl.key;
                end
                else
                begin
                    key_next = left_key;
                end
            end
            sus_pkg::CELL_DELETE:
            begin
                key_next = lt ? key_reg : right_key;
            end
            sus_pkg::CELL_ROTATE:
            begin
                key_next = tail ? wrap_key : right_key;
            end
            default:
            begin
                key_next = key_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

endmodule

`default_nettype wire

/* rtl/core/sorted_unique_key_set_top.sv */
// Sorted unique key set: a chain of DEPTH compare-and-shift cells.
// Insert, delete and search: one result in the cycle after the request; a new
// request can be taken every cycle while not busy. List: one result per stored
// key (or one empty status), paced by rotating the chain one slot per cycle;
// busy holds while keys remain to be sent. Reset (rst_n, async low) empties
// the set; the receiver cannot stall. Depends on sus_pkg and sus_cell.
`default_nettype none

module sorted_unique_key_set_top #(
    parameter int DEPTH = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire sus_pkg::request_t request,
    output logic                   strobe,
    output sus_pkg::result_t       result
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    sus_pkg::seq_state_t state_reg;
    sus_pkg::seq_state_t state_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [CNT_W-1:0]    remain_reg;
    logic [CNT_W-1:0]    remain_next;
    logic                strobe_reg;
    logic                strobe_next;
    sus_pkg::result_t    result_reg;
    sus_pkg::result_t    result_next;

    sus_pkg::cell_ctl_t  ctl;
    logic signed [31:0]  key_vec [DEPTH];
    logic [DEPTH-1:0]    lt_vec;
    logic [DEPTH-1:0]    eq_vec;
    logic                accept;
    logic                hit;
    logic                full;

    assign busy   = (state_reg == sus_pkg::SEQ_LIST);
    assign accept = start && !busy;
    assign hit    = |eq_vec;
    assign full   = (count_reg == CNT_W'(DEPTH));
    assign strobe = strobe_reg;
    assign result = result_reg;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic               left_lt_w;
            logic signed [31:0] left_key_w;
            logic signed [31:0] right_key_w;

            if (gi == 0)
            begin : g_head
                assign left_lt_w  = 1'b1;
                assign left_key_w = ctl.key;
            end
            else
            begin : g_body
                assign left_lt_w  = lt_vec[gi-1];
                assign left_key_w = key_vec[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_end
                assign right_key_w = key_vec[gi];
            end
            else
            begin : g_mid
                assign right_key_w = key_vec[gi+1];
            end

            sus_cell u_cell (
                .clk       (clk),
                .occupied  (count_reg > CNT_W'(gi)),
                .tail      (count_reg == CNT_W'(gi + 1)),
                .ctl       (ctl),
                .left_lt   (left_lt_w),
                .left_key  (left_key_w),
                .right_key (right_key_w),
                .wrap_key  (key_vec[0]),
                .key       (key_vec[gi]),
                .lt        (lt_vec[gi]),
                .eq        (eq_vec[gi])
            );
        end
    endgenerate

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sus_pkg::SEQ_IDLE:
            begin
                if (accept && (request.operation == sus_pkg::OP_LIST) &&
                    (count_reg > CNT_W'(1)))
                begin
                    state_next = sus_pkg::SEQ_LIST;
                end
            end
            sus_pkg::SEQ_LIST:
            begin
                if (remain_reg == CNT_W'(1))
                begin
                    state_next = sus_pkg::SEQ_IDLE;
                end
            end
            default:
            begin
                state_next = sus_pkg::SEQ_IDLE;
            end
        endcase
    end

    // cell commands, result and counters
    always_comb
    begin
        ctl.cmd                 = sus_pkg::CELL_HOLD;
        ctl.key                 = request.key;
        count_next              = count_reg;
        remain_next             = remain_reg;
        strobe_next             = 1'b0;
        result_next.status      = sus_pkg::STAT_OK;
        result_next.value       = request.key;
        result_next.entry_count = 5'(count_reg);
        result_next.last        = 1'b1;

        unique case (state_reg)
            sus_pkg::SEQ_IDLE:
            begin
                if (accept)
                begin
                    strobe_next = 1'b1;
                    unique case (request.operation)
                        sus_pkg::OP_INSERT:
                        begin
                            if (hit)
                            begin
                                result_next.status = sus_pkg::STAT_DUP;
                            end
                            else if (full)
                            begin
                                result_next.status = sus_pkg::STAT_FULL;
                            end
                            else
                            begin
                                ctl.cmd                 = sus_pkg::CELL_INSERT;
                                count_next              = count_reg + CNT_W'(1);
                                result_next.entry_count = 5'(count_next);
                            end
                        end
                        sus_pkg::OP_DELETE:
                        begin
                            if (hit)
                            begin
                                ctl.cmd                 = sus_pkg::CELL_DELETE;
                                count_next              = count_reg - CNT_W'(1);
                                result_next.entry_count = 5'(count_next);
                            end
                            else
                            begin
                                result_next.status = sus_pkg::STAT_NOT_FOUND;
                            end
                        end
                        sus_pkg::OP_SEARCH:
                        begin
                            result_next.status = hit ? sus_pkg::STAT_OK
                                                     : sus_pkg::STAT_NOT_FOUND;
                        end
                        sus_pkg::OP_LIST:
                        begin
                            if (count_reg == '0)
                            begin
                                result_next.status = sus_pkg::STAT_EMPTY;
                                result_next.value  = '0;
                            end
                            else
                            begin
                                // head cell leaves, chain rotates left one slot
                                ctl.cmd           = sus_pkg::CELL_ROTATE;
                                result_next.value = key_vec[0];
                                result_next.last  = (count_reg == CNT_W'(1));
                                remain_next       = count_reg - CNT_W'(1);
                            end
                        end
                        default:
                        begin
                            result_next.status = sus_pkg::STAT_OK;
                        end
                    endcase
                end
            end
            sus_pkg::SEQ_LIST:
            begin
                ctl.cmd           = sus_pkg::CELL_ROTATE;
                strobe_next       = 1'b1;
                result_next.value = key_vec[0];
                result_next.last  = (remain_reg == CNT_W'(1));
                remain_next       = remain_reg - CNT_W'(1);
            end
            default:
            begin
                strobe_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= sus_pkg::SEQ_IDLE;
            count_reg  <= '0;
            remain_reg <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            remain_reg <= remain_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

endmodule

`default_nettype wire

/* verif/tb.sv */
// Self-checking testbench for sorted_unique_key_set_top: a directed table, then
// about 450 random insert/delete/search/list requests with a built-in predictor.
// Depends on sus_pkg and the sorted_unique_key_set_top RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 16;
    localparam int STALL_LIMIT = 2000;
    localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] KEY_MAX = 32'sh7fff_ffff;

    typedef struct {
        sus_pkg::op_t       op;
        logic signed [31:0] key;
        int                 reps;    // repeated with key + 1 each time
        logic               typed;   // expected result given in the row
        sus_pkg::status_t   status;
        logic signed [31:0] value;
        logic [4:0]         count;
    } smoke_row_t;

    typedef struct {
        logic             typed;
        sus_pkg::result_t res;
    } typed_check_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    sus_pkg::request_t request = '0;
    logic              busy;
    logic              strobe;
    sus_pkg::result_t  result;

    // predictor state
    logic signed [31:0] set_keys [DEPTH];
    int                 set_count = 0;
    sus_pkg::result_t   step_results [$];

    sus_pkg::result_t expected_results [$];
    typed_check_t     typed_checks [$];
    int               err_count = 0;
    int               stall_cycles = 0;
    smoke_row_t       smoke_rows [21];

    sorted_unique_key_set_top #(
        .DEPTH(DEPTH)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .request(request),
        .strobe(strobe),
        .result(result)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic sus_pkg::result_t make_result(sus_pkg::status_t s,
                                                     logic signed [31:0] v, logic lst);
        sus_pkg::result_t r;
        r.status      = s;
        r.value       = v;
        r.entry_count = 5'(set_count);
        r.last        = lst;
        return r;
    endfunction

    // Fills step_results with what one request produces and updates the set.
    function automatic void predict_request(sus_pkg::request_t req);
        int   pos;
        int   i;
        logic hit;
        step_results.delete();
        if (req.operation == sus_pkg::OP_LIST)
        begin
            if (set_count == 0)
                step_results.push_back(make_result(sus_pkg::STAT_EMPTY, 32'sd0, 1'b1));
            for (i = 0; i < set_count; i++)
                step_results.push_back(make_result(sus_pkg::STAT_OK, set_keys[i],
                                                   i + 1 == set_count));
            return;
        end
        pos = 0;
        while (pos < set_count && set_keys[pos] < req.key)
            pos++;
        hit = (pos < set_count) && (set_keys[pos] == req.key);
        case (req.operation)
            sus_pkg::OP_INSERT:
            begin
                if (hit)
                    step_results.push_back(make_result(sus_pkg::STAT_DUP, req.key, 1'b1));
                else if (set_count >= DEPTH)
                    step_results.push_back(make_result(sus_pkg::STAT_FULL, req.key, 1'b1));
                else
                begin
                    for (i = set_count; i > pos; i--)
                        set_keys[i] = set_keys[i - 1];
                    set_keys[pos] = req.key;
                    set_count++;
                    step_results.push_back(make_result(sus_pkg::STAT_OK, req.key, 1'b1));
                end
            end
            sus_pkg::OP_DELETE:
            begin
                if (hit)
                begin
                    for (i = pos; i + 1 < set_count; i++)
                        set_keys[i] = set_keys[i + 1];
                    set_count--;
                    step_results.push_back(make_result(sus_pkg::STAT_OK, req.key, 1'b1));
                end
                else
                    step_results.push_back(make_result(sus_pkg::STAT_NOT_FOUND, req.key,
                                                       1'b1));
            end
            default:
                step_results.push_back(make_result(hit ? sus_pkg::STAT_OK
                                                       : sus_pkg::STAT_NOT_FOUND,
                                                   req.key, 1'b1));
        endcase
    endfunction

    // Result check, request capture and stall watchdog.
    always @(posedge clk)
    begin : monitor
        sus_pkg::result_t want;
        typed_check_t     chk;
        logic             moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (strobe)
            begin
                moved = 1'b1;
                if (expected_results.size() == 0)
                begin
                    err_count++;
                    $display("%0t: unexpected result status %0d value %0d count %0d last %0d",
                             $time, result.status, result.value, result.entry_count,
                             result.last);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result.status !== want.status || result.value !== want.value ||
                        result.entry_count !== want.entry_count || result.last !== want.last)
                    begin
                        err_count++;
                        $display("%0t: mismatch expected status %0d value %0d count %0d last %0d",
                                 $time, want.status, want.value, want.entry_count, want.last);
                        $display("%0t:          got      status %0d value %0d count %0d last %0d",
                                 $time, result.status, result.value, result.entry_count,
                                 result.last);
                    end
                end
            end
            if (start && !busy)
            begin
                moved = 1'b1;
                chk.typed = 1'b0;
                if (typed_checks.size() != 0)
                    chk = typed_checks.pop_front();
                predict_request(request);
                if (chk.typed)
                    expected_results.push_back(chk.res);
                else
                    foreach (step_results[i])
                        expected_results.push_back(step_results[i]);
            end
        end
        stall_cycles = moved ? 0 : stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("simulation failed");
            $finish;
        end
    end

    // Drives one request and returns at the edge that accepts it.
    task automatic send_request(sus_pkg::op_t op, logic signed [31:0] key, logic typed,
                                sus_pkg::result_t typed_res, int idle_pct);
        typed_check_t chk;
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        chk.typed = typed;
        chk.res   = typed_res;
        typed_checks.push_back(chk);
        start   <= 1'b1;
        request <= '{operation: op, key: key};
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (expected_results.size() != 0 || typed_checks.size() != 0)
            @(posedge clk);
    endtask

    // Mostly keys that collide: stored ones and a narrow window around zero.
    function automatic logic signed [31:0] pick_key();
        int sel;
        int v;
        sel = $urandom_range(99);
        if (sel < 35 && set_count > 0)
            return set_keys[$urandom_range(set_count - 1)];
        if (sel < 65)
        begin
            v = $urandom_range(40);
            return v - 20;
        end
        if (sel < 75)
        begin
            case ($urandom_range(3))
                0: return KEY_MIN;
                1: return KEY_MAX;
                2: return 32'sd0;
                default: return -32'sd1;
            endcase
        end
        return $urandom();
    endfunction

    function automatic sus_pkg::op_t pick_op(int ins_pct, int del_pct, int srch_pct);
        int sel;
        sel = $urandom_range(99);
        if (sel < ins_pct)
            return sus_pkg::OP_INSERT;
        if (sel < ins_pct + del_pct)
            return sus_pkg::OP_DELETE;
        if (sel < ins_pct + del_pct + srch_pct)
            return sus_pkg::OP_SEARCH;
        return sus_pkg::OP_LIST;
    endfunction

    initial
    begin : stimulus
        sus_pkg::result_t r;
        int               n;
        int               p;
        int               ins_pct [6];
        int               del_pct [6];
        int               srch_pct [6];
        int               idle_pct [6];

        smoke_rows = '{
            '{sus_pkg::OP_SEARCH, 32'sd0,   1, 1'b1, sus_pkg::STAT_NOT_FOUND, 32'sd0,   5'd0},
            '{sus_pkg::OP_DELETE, 32'sd5,   1, 1'b1, sus_pkg::STAT_NOT_FOUND, 32'sd5,   5'd0},
            '{sus_pkg::OP_LIST,   KEY_MAX,  1, 1'b1, sus_pkg::STAT_EMPTY,     32'sd0,   5'd0},
            '{sus_pkg::OP_INSERT, KEY_MIN,  1, 1'b1, sus_pkg::STAT_OK,        KEY_MIN,  5'd1},
            '{sus_pkg::OP_INSERT, KEY_MAX,  1, 1'b1, sus_pkg::STAT_OK,        KEY_MAX,  5'd2},
            '{sus_pkg::OP_INSERT, 32'sd0,   1, 1'b1, sus_pkg::STAT_OK,        32'sd0,   5'd3},
            '{sus_pkg::OP_INSERT, 32'sd0,   1, 1'b1, sus_pkg::STAT_DUP,       32'sd0,   5'd3},
            '{sus_pkg::OP_INSERT, -32'sd1,  1, 1'b1, sus_pkg::STAT_OK,        -32'sd1,  5'd4},
            '{sus_pkg::OP_SEARCH, KEY_MIN,  1, 1'b1, sus_pkg::STAT_OK,        KEY_MIN,  5'd4},
            '{sus_pkg::OP_SEARCH, 32'sd1,   1, 1'b1, sus_pkg::STAT_NOT_FOUND, 32'sd1,   5'd4},
            '{sus_pkg::OP_LIST,   32'sd0,   1, 1'b0, sus_pkg::STAT_OK,        32'sd0,   5'd0},
            '{sus_pkg::OP_DELETE, KEY_MAX,  1, 1'b1, sus_pkg::STAT_OK,        KEY_MAX,  5'd3},
            '{sus_pkg::OP_DELETE, KEY_MAX,  1, 1'b1, sus_pkg::STAT_NOT_FOUND, KEY_MAX,  5'd3},
            '{sus_pkg::OP_INSERT, 32'sd100, 13, 1'b0, sus_pkg::STAT_OK,       32'sd0,   5'd0},
            '{sus_pkg::OP_INSERT, 32'sd5,   1, 1'b1, sus_pkg::STAT_FULL,      32'sd5,   5'd16},
            '{sus_pkg::OP_INSERT, 32'sd100, 1, 1'b1, sus_pkg::STAT_DUP,       32'sd100, 5'd16},
            '{sus_pkg::OP_LIST,   -32'sd1,  1, 1'b0, sus_pkg::STAT_OK,        32'sd0,   5'd0},
            '{sus_pkg::OP_DELETE, KEY_MIN,  1, 1'b1, sus_pkg::STAT_OK,        KEY_MIN,  5'd15},
            '{sus_pkg::OP_INSERT, -32'sd5,  1, 1'b1, sus_pkg::STAT_OK,        -32'sd5,  5'd16},
            '{sus_pkg::OP_SEARCH, -32'sd5,  1, 1'b1, sus_pkg::STAT_OK,        -32'sd5,  5'd16},
            '{sus_pkg::OP_LIST,   32'sd0,   1, 1'b0, sus_pkg::STAT_OK,        32'sd0,   5'd0}
        };

        // fill, mixed, drain, fill, mixed without gaps, drain
        ins_pct  = '{60, 35, 20, 65, 35, 15};
        del_pct  = '{10, 30, 55, 10, 30, 60};
        srch_pct = '{20, 25, 15, 15, 25, 15};
        idle_pct = '{17, 17, 17, 17,  0, 17};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (smoke_rows[i])
        begin
            for (n = 0; n < smoke_rows[i].reps; n++)
            begin
                r.status      = smoke_rows[i].status;
                r.value       = smoke_rows[i].value;
                r.entry_count = smoke_rows[i].count;
                r.last        = 1'b1;
                send_request(smoke_rows[i].op, smoke_rows[i].key + n,
                             smoke_rows[i].typed, r, 17);
            end
        end
        drain_results();

        r = '0;
        for (p = 0; p < 6; p++)
        begin
            for (n = 0; n < 75; n++)
                send_request(pick_op(ins_pct[p], del_pct[p], srch_pct[p]), pick_key(),
                             1'b0, r, idle_pct[p]);
            // hold off until every result is back
            drain_results();
        end

        repeat (4) @(posedge clk);
        if (err_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* sorted_unique_key_set_top.f */
rtl/core/sus_pkg.sv
rtl/core/sus_cell.sv
rtl/core/sorted_unique_key_set_top.sv
verif/tb.sv
